/* hdl/multi_channel_heartbeat_monitor_assert.svh */
// assertion macros for the heartbeat monitor checker
`ifndef MULTI_CHANNEL_HEARTBEAT_MONITOR_ASSERT_SVH
`define MULTI_CHANNEL_HEARTBEAT_MONITOR_ASSERT_SVH
`define HBM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define HBM_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* hdl/hbm_pkg.sv */
// shared types and constants for the heartbeat monitor
package hbm_pkg;
    localparam int unsigned CHANNELS_DEF = 8;
    localparam logic [15:0] WINDOW_RESET = 16'd100;
    localparam logic [15:0] NEVER_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_FEED       = 2'd2,
        OP_TICK       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_DIVIDE,
        S_SCAN,
        S_READ,
        S_WRITE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cmd_exec;
        logic div_start;
        logic div_step;
        logic scan_clear;
        logic scan_next;
        logic read_slot;
        logic write_slot;
    } hbm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic any_used;
        logic div_done;
        logic scan_end;
        logic slot_used;
    } hbm_stat_t;
endpackage

/* hdl/hbm_ctrl.sv */
// controller state machine for the heartbeat monitor
module hbm_ctrl
    import hbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  hbm_stat_t stat,
    output hbm_cmd_t  cmd,
    output logic      busy
);
    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (stat.is_tick && stat.any_used)
                begin
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.slot_used)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_CMD:
            begin
                cmd.cmd_exec = 1'b1;
                cmd.div_start = stat.is_tick && stat.any_used;
                cmd.scan_clear = 1'b1;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_next = !stat.slot_used && !stat.scan_end;
            end
            S_READ:
            begin
                cmd.read_slot = 1'b1;
            end
            S_WRITE:
            begin
                cmd.write_slot = 1'b1;
                cmd.scan_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

/* hdl/hbm_datapath.sv */
// slot storage, tick arithmetic and result register
module hbm_datapath
    import hbm_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  hbm_cmd_t    cmd,
    output hbm_stat_t   stat,
    input  logic [15:0] window_ms,
    input  logic [1:0]  opcode,
    input  logic [2:0]  channel,
    input  logic [31:0] now_ms,
    input  logic [15:0] init_wait_ms,
    input  logic [15:0] timeout_ms,
    output logic        done,
    output logic [2:0]  out_channel,
    output logic        online,
    output logic        changed,
    output logic [31:0] feed_interval_ms,
    output logic [1:0]  status,
    output logic        last
);
    localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned CW = $clog2(CHANNELS + 1);

    // per-slot store, no reset except the used bits
    logic [15:0] wait_lim   [CHANNELS];
    logic [15:0] to_lim     [CHANNELS];
    logic [31:0] feed_now   [CHANNELS];
    logic [31:0] feed_prev  [CHANNELS];
    logic [31:0] wait_cnt   [CHANNELS];
    logic [15:0] stable_cnt [CHANNELS];
    logic        on_now     [CHANNELS];
    logic        on_prev    [CHANNELS];
    logic [31:0] ivl_hold   [CHANNELS];
    logic [CHANNELS-1:0] used_reg;

    logic [1:0]  op_reg;
    logic [2:0]  ch_reg;
    logic [31:0] now_reg;
    logic [15:0] iw_reg;
    logic [15:0] to_reg;
    logic [31:0] prev_tick_reg;
    logic        first_tick_reg;
    logic [31:0] diff_reg;

    // restoring divider for window / diff
    logic [15:0] quot_reg;
    logic [31:0] rem_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic [32:0] rem_shift;
    logic [15:0] thr;

    logic [CW-1:0] scan_reg;
    logic [IW-1:0] slot;
    logic          ch_valid;
    logic [IW-1:0] ch_idx;
    logic          ch_used;

    // values read for the current scan slot
    logic [15:0] r_wlim;
    logic [15:0] r_tlim;
    logic [31:0] r_fnow;
    logic [31:0] r_fprev;
    logic [31:0] r_wcnt;
    logic [15:0] r_scnt;
    logic        r_on;
    logic        r_onp;
    logic [31:0] r_ivl;
    logic [31:0] r_age;

    logic [31:0] n_wcnt;
    logic [15:0] n_scnt;
    logic        n_on;
    logic [31:0] n_ivl;
    logic [32:0] wsum;
    logic [16:0] sc_inc;
    logic [CHANNELS-1:0] higher_mask;
    logic        is_last;

    assign slot = scan_reg[IW-1:0];
    assign ch_valid = ({29'd0, ch_reg} < 32'(CHANNELS));
    assign ch_idx = IW'(ch_reg);
    assign ch_used = ch_valid && used_reg[ch_idx];

    assign stat.is_tick = (op_reg == OP_TICK);
    assign stat.any_used = |used_reg;
    assign stat.div_done = div_busy_reg && (div_cnt_reg == 5'd0);
    assign stat.scan_end = (scan_reg == CW'(CHANNELS));
    assign stat.slot_used = !stat.scan_end && used_reg[slot];

    assign rem_shift = {rem_reg, quot_reg[15]};
    assign thr = (quot_reg == 16'd0) ? 16'd1 : quot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            ch_reg  <= channel;
            now_reg <= now_ms;
            iw_reg  <= init_wait_ms;
            to_reg  <= timeout_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tick_reg  <= '0;
            first_tick_reg <= 1'b1;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            scan_reg       <= '0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                prev_tick_reg  <= now_reg;
                first_tick_reg <= 1'b0;
                div_busy_reg   <= 1'b1;
                div_cnt_reg    <= 5'd16;
            end
            else if (cmd.div_step)
            begin
                if (div_cnt_reg == 5'd0)
                begin
                    div_busy_reg <= 1'b0;
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
            end
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
        end
    end

    // one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            if (first_tick_reg || (now_reg == prev_tick_reg))
            begin
                diff_reg <= 32'd1;
            end
            else
            begin
                diff_reg <= now_reg - prev_tick_reg;
            end
            quot_reg <= window_ms;
            rem_reg  <= '0;
        end
        else if (cmd.div_step && div_cnt_reg != 5'd0)
        begin
            if (rem_shift >= {1'b0, diff_reg})
            begin
                rem_reg  <= 32'(rem_shift - {1'b0, diff_reg});
                quot_reg <= {quot_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[31:0];
                quot_reg <= {quot_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_slot)
        begin
            r_wlim  <= wait_lim[slot];
            r_tlim  <= to_lim[slot];
            r_fnow  <= feed_now[slot];
            r_fprev <= feed_prev[slot];
            r_wcnt  <= wait_cnt[slot];
            r_scnt  <= stable_cnt[slot];
            r_on    <= on_now[slot];
            r_onp   <= on_prev[slot];
            r_ivl   <= ivl_hold[slot];
            r_age   <= now_reg - feed_now[slot];
        end
    end

    always_comb
    begin
        n_wcnt = r_wcnt;
        n_scnt = r_scnt;
        n_on = r_on;
        wsum = {1'b0, r_wcnt} + {1'b0, diff_reg};
        sc_inc = {1'b0, r_scnt} + 17'd1;
        if (r_wcnt <= {16'd0, r_wlim})
        begin
            n_wcnt = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
            if (n_wcnt > {16'd0, r_wlim})
            begin
                n_on = 1'b1;
            end
        end
        else if (r_age > {16'd0, r_tlim})
        begin
            n_on = (r_tlim == NEVER_LIMIT) || (r_tlim == 16'd0);
            n_scnt = '0;
        end
        else if (sc_inc >= {1'b0, thr})
        begin
            n_scnt = '0;
            n_on = 1'b1;
        end
        else
        begin
            n_scnt = sc_inc[15:0];
        end
        n_ivl = (r_fnow > r_fprev) ? (r_fnow - r_fprev) : r_ivl;
        for (int i = 0; i < CHANNELS; i++)
        begin
            higher_mask[i] = (i > int'(slot));
        end
        is_last = ((used_reg & higher_mask) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmd_exec && op_reg == OP_REGISTER && ch_valid && !ch_used)
        begin
            wait_lim[ch_idx]   <= iw_reg;
            to_lim[ch_idx]     <= to_reg;
            feed_now[ch_idx]   <= now_reg;
            feed_prev[ch_idx]  <= now_reg;
            wait_cnt[ch_idx]   <= '0;
            stable_cnt[ch_idx] <= '0;
            on_now[ch_idx]     <= 1'b1;
            on_prev[ch_idx]    <= 1'b1;
            ivl_hold[ch_idx]   <= '0;
        end
        else if (cmd.cmd_exec && op_reg == OP_FEED && ch_used)
        begin
            feed_prev[ch_idx] <= feed_now[ch_idx];
            feed_now[ch_idx]  <= now_reg;
        end
        else if (cmd.write_slot)
        begin
            wait_cnt[slot]   <= n_wcnt;
            stable_cnt[slot] <= n_scnt;
            on_now[slot]     <= n_on;
            on_prev[slot]    <= n_on;
            ivl_hold[slot]   <= n_ivl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cmd.cmd_exec)
            begin
                if (op_reg == OP_REGISTER && ch_valid && !ch_used)
                begin
                    used_reg[ch_idx] <= 1'b1;
                end
                else if (op_reg == OP_UNREGISTER && ch_used)
                begin
                    used_reg[ch_idx] <= 1'b0;
                end
                done <= (op_reg != OP_TICK);
            end
            else if (cmd.write_slot)
            begin
                done <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmd_exec)
        begin
            out_channel <= ch_reg;
            changed <= 1'b0;
            last <= 1'b1;
            unique case (op_reg)
                OP_REGISTER:
                begin
                    if (!ch_valid)
                    begin
                        online <= 1'b0;
                        feed_interval_ms <= '0;
                        status <= ST_MISSING;
                    end
                    else if (ch_used)
                    begin
                        online <= on_now[ch_idx];
                        feed_interval_ms <= ivl_hold[ch_idx];
                        status <= ST_ALREADY;
                    end
                    else
                    begin
                        online <= 1'b1;
                        feed_interval_ms <= '0;
                        status <= ST_OK;
                    end
                end
                OP_FEED:
                begin
                    online <= ch_used ? on_now[ch_idx] : 1'b0;
                    feed_interval_ms <= ch_used ? ivl_hold[ch_idx] : 32'd0;
                    status <= ch_used ? ST_OK : ST_MISSING;
                end
                default:
                begin
                    online <= 1'b0;
                    feed_interval_ms <= '0;
                    status <= ch_used ? ST_OK : ST_MISSING;
                end
            endcase
        end
        else if (cmd.write_slot)
        begin
            out_channel <= 3'(slot);
            online <= n_on;
            changed <= (n_on != r_onp);
            feed_interval_ms <= n_ivl;
            status <= ST_OK;
            last <= is_last;
        end
    end
endmodule

/* hdl/multi_channel_heartbeat_monitor.sv */
// top level of the multi-channel heartbeat monitor
//
// channel  | handshake            | payload
// command  | start / busy         | opcode channel now_ms init_wait_ms timeout_ms
// result   | done (one cycle)     | out_channel online changed feed_interval_ms status last
// config   | cfg_valid / cfg_ready| cfg_data (stable_window_ms)
//
// register, unregister and feed stay busy only for the command state, result beat next
// a tick runs the command state, then the 16-step divider, then scans every slot,
// with a read and a write state per armed slot, and finishes at the scan end
// with no armed slot a tick gives no result and leaves the tick timer alone
// reset sets the window to 100 and frees all slots; results cannot be stalled
module multi_channel_heartbeat_monitor
    import hbm_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [2:0]  channel,
    input  logic [31:0] now_ms,
    input  logic [15:0] init_wait_ms,
    input  logic [15:0] timeout_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [2:0]  out_channel,
    output logic        online,
    output logic        changed,
    output logic [31:0] feed_interval_ms,
    output logic [1:0]  status,
    output logic        last
);
    hbm_cmd_t    cmd;
    hbm_stat_t   stat;
    logic [15:0] window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            window_reg <= cfg_data;
        end
    end

    hbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    hbm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .window_ms        (window_reg),
        .opcode           (opcode),
        .channel          (channel),
        .now_ms           (now_ms),
        .init_wait_ms     (init_wait_ms),
        .timeout_ms       (timeout_ms),
        .done             (done),
        .out_channel      (out_channel),
        .online           (online),
        .changed          (changed),
        .feed_interval_ms (feed_interval_ms),
        .status           (status),
        .last             (last)
    );
endmodule

/* hdl/hbm_checker.sv */
// port-level checker for the heartbeat monitor, bound to the top level
`include "multi_channel_heartbeat_monitor_assert.svh"
module hbm_checker
    import hbm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       changed,
    input logic [1:0] status
);
    // a beat is accepted only while idle, so the next cycle is busy
    `HBM_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `HBM_ASSERT_IMP(a_status_code, clk, rst_n, done, status != 2'd3)
    `HBM_ASSERT_IMP(a_changed_ok, clk, rst_n, done && changed, status == ST_OK)
endmodule

bind multi_channel_heartbeat_monitor hbm_checker u_hbm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .changed (changed),
    .status  (status)
);
